// ===== rtl/core/matrix4_vector_transform_top_assert.svh =====
// Assertion macros shared by the transform checker.
`ifndef MATRIX4_VECTOR_TRANSFORM_TOP_ASSERT_SVH
`define MATRIX4_VECTOR_TRANSFORM_TOP_ASSERT_SVH

// Antecedent implies consequent, checked on every clock edge out of reset.
`define MVT_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> cons) \
    else $error("assertion failed");

// Antecedent implies consequent in the next cycle.
`define MVT_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> cons) \
    else $error("assertion failed");

`endif

// ===== rtl/core/mvt_pkg.sv =====
// Types and constants for the 4x4 matrix-vector transform.
package mvt_pkg;

  localparam int DIM    = 4;
  localparam int COEF_W = 16;
  localparam int ROW_W  = DIM * COEF_W;
  localparam int PROD_W = 2 * COEF_W;
  localparam int SUM_W  = PROD_W + 2;
  localparam int IDX_W  = 3;

  // Configuration register indexes
  localparam logic [IDX_W-1:0] REG_ROW0 = 3'd0;
  localparam logic [IDX_W-1:0] REG_ROW1 = 3'd1;
  localparam logic [IDX_W-1:0] REG_ROW2 = 3'd2;
  localparam logic [IDX_W-1:0] REG_ROW3 = 3'd3;
  localparam logic [IDX_W-1:0] REG_MODE = 3'd4;

  // Identity rows (Q4.12 one on the diagonal)
  localparam logic [ROW_W-1:0] ROW0_RESET = 64'h0000_0000_0000_1000;
  localparam logic [ROW_W-1:0] ROW1_RESET = 64'h0000_0000_1000_0000;
  localparam logic [ROW_W-1:0] ROW2_RESET = 64'h0000_1000_0000_0000;
  localparam logic [ROW_W-1:0] ROW3_RESET = 64'h1000_0000_0000_0000;

  // Matrix: [row][col], column j of a row at bits 16j+15..16j
  typedef logic [DIM-1:0][DIM-1:0][COEF_W-1:0] matrix_t;
  typedef logic [DIM-1:0][COEF_W-1:0]          vec_arr_t;
  typedef logic [DIM-1:0][DIM-1:0][PROD_W-1:0] prod_arr_t;

  typedef struct packed {
    logic signed [COEF_W-1:0] vec_in0;
    logic signed [COEF_W-1:0] vec_in1;
    logic signed [COEF_W-1:0] vec_in2;
    logic signed [COEF_W-1:0] vec_in3;
  } vec_in_t;

  typedef struct packed {
    logic signed [COEF_W-1:0] vec_out0;
    logic signed [COEF_W-1:0] vec_out1;
    logic signed [COEF_W-1:0] vec_out2;
    logic signed [COEF_W-1:0] vec_out3;
    logic                     saturated_flag;
  } vec_out_t;

  // Configuration seen by the datapath
  typedef struct packed {
    matrix_t matrix;
    logic    row_vector_mode;
  } cfg_t;

endpackage

// ===== rtl/core/mvt_cfg_regs.sv =====
// Matrix and mode configuration registers.
module mvt_cfg_regs
  import mvt_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_index,
  input  logic [ROW_W-1:0] wr_data,
  output cfg_t             cfg
);

  matrix_t matrix;
  logic    row_vector_mode;

  // Register writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      matrix[0]       <= ROW0_RESET;
      matrix[1]       <= ROW1_RESET;
      matrix[2]       <= ROW2_RESET;
      matrix[3]       <= ROW3_RESET;
      row_vector_mode <= 1'b0;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_ROW0: matrix[0] <= wr_data;
        REG_ROW1: matrix[1] <= wr_data;
        REG_ROW2: matrix[2] <= wr_data;
        REG_ROW3: matrix[3] <= wr_data;
        REG_MODE: row_vector_mode <= wr_data[0];
        default: ;
      endcase
    end
  end

  assign cfg.matrix          = matrix;
  assign cfg.row_vector_mode = row_vector_mode;

endmodule

// ===== rtl/core/mvt_mult_stage.sv =====
// Sixteen-multiplier bank with registered products.
module mvt_mult_stage
  import mvt_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  vec_arr_t  vec,
  input  cfg_t      cfg,
  output logic      prod_valid,
  output prod_arr_t prod
);

  matrix_t coef;

  // Pick M[i][j] or, in row-vector mode, M[j][i]
  always_comb begin
    for (int i = 0; i < DIM; i++) begin
      for (int j = 0; j < DIM; j++) begin
        coef[i][j] = cfg.row_vector_mode ? cfg.matrix[j][i] : cfg.matrix[i][j];
      end
    end
  end

  // Product registers
  always_ff @(posedge clk) begin
    for (int i = 0; i < DIM; i++) begin
      for (int j = 0; j < DIM; j++) begin
        prod[i][j] <= $signed(coef[i][j]) * $signed(vec[j]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
    end else begin
      prod_valid <= in_valid;
    end
  end

endmodule

// ===== rtl/core/mvt_sum_sat.sv =====
// Row sums, fixed-point shift, saturation and result register.
module mvt_sum_sat
  import mvt_pkg::*;
#(
  parameter int FRAC_BITS = 12
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      prod_valid,
  input  prod_arr_t prod,
  output logic      result_strobe,
  output vec_out_t  result
);

  logic signed [SUM_W-1:0]  sum     [DIM];
  logic signed [SUM_W-1:0]  shifted [DIM];
  logic [SUM_W-COEF_W:0]    hi      [DIM];
  logic [DIM-1:0]           clip;
  vec_arr_t                 sat;

  // Sum four products, floor shift, clip to 16 bits
  always_comb begin
    for (int i = 0; i < DIM; i++) begin
      sum[i] = '0;
      for (int j = 0; j < DIM; j++) begin
        sum[i] = sum[i] + {{(SUM_W-PROD_W){prod[i][j][PROD_W-1]}}, prod[i][j]};
      end
      shifted[i] = sum[i] >>> FRAC_BITS;
      hi[i]      = shifted[i][SUM_W-1:COEF_W-1];
      if (!shifted[i][SUM_W-1] && (|hi[i])) begin
        sat[i]  = {1'b0, {(COEF_W-1){1'b1}}};
        clip[i] = 1'b1;
      end else if (shifted[i][SUM_W-1] && !(&hi[i])) begin
        sat[i]  = {1'b1, {(COEF_W-1){1'b0}}};
        clip[i] = 1'b1;
      end else begin
        sat[i]  = shifted[i][COEF_W-1:0];
        clip[i] = 1'b0;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    result.vec_out0       <= sat[0];
    result.vec_out1       <= sat[1];
    result.vec_out2       <= sat[2];
    result.vec_out3       <= sat[3];
    result.saturated_flag <= |clip;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_strobe <= 1'b0;
    end else begin
      result_strobe <= prod_valid;
    end
  end

endmodule

// ===== rtl/core/matrix4_vector_transform_top.sv =====
// Top level of the 4x4 matrix-vector transform.
//
//   channel   handshake              payload
//   input     start, busy            vec_in   (vec_in_t)
//   result    result_strobe          result   (vec_out_t)
//   config    wr_en                  wr_index, wr_data
//
// One item is taken every cycle while busy is low; its result is registered through the
// input register, the multiplier bank and the adder/saturate register before it strobes.
// Throughput is set by the 16 parallel 16x16 multipliers, one per matrix entry.
// Synchronous reset restores the identity matrix and column-vector mode;
// busy is high only during reset. Results cannot be stalled.
module matrix4_vector_transform_top
  import mvt_pkg::*;
#(
  parameter int FRAC_BITS = 12
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  vec_in_t          vec_in,
  output logic             result_strobe,
  output vec_out_t         result,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_index,
  input  logic [ROW_W-1:0] wr_data
);

  cfg_t      cfg;
  logic      in_valid;
  vec_arr_t  vec;
  logic      prod_valid;
  prod_arr_t prod;

  assign busy = rst;

  mvt_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .cfg      (cfg)
  );

  // Input register
  always_ff @(posedge clk) begin
    vec[0] <= vec_in.vec_in0;
    vec[1] <= vec_in.vec_in1;
    vec[2] <= vec_in.vec_in2;
    vec[3] <= vec_in.vec_in3;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= start && !busy;
    end
  end

  mvt_mult_stage u_mult (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .vec        (vec),
    .cfg        (cfg),
    .prod_valid (prod_valid),
    .prod       (prod)
  );

  mvt_sum_sat #(
    .FRAC_BITS (FRAC_BITS)
  ) u_sum (
    .clk           (clk),
    .rst           (rst),
    .prod_valid    (prod_valid),
    .prod          (prod),
    .result_strobe (result_strobe),
    .result        (result)
  );

endmodule

// ===== rtl/core/mvt_checker.sv =====
// Port-level checker for the transform, bound to the top level.
`include "matrix4_vector_transform_top_assert.svh"

module mvt_checker
  import mvt_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             start,
  input logic             busy,
  input vec_in_t          vec_in,
  input logic             result_strobe,
  input vec_out_t         result,
  input logic             wr_en,
  input logic [IDX_W-1:0] wr_index,
  input logic [ROW_W-1:0] wr_data
);

  logic accept;
  logic rail0, rail1, rail2, rail3;

  assign accept = start && !busy;
  assign rail0  = (result.vec_out0 == 16'sh7fff) || (result.vec_out0 == -16'sh8000);
  assign rail1  = (result.vec_out1 == 16'sh7fff) || (result.vec_out1 == -16'sh8000);
  assign rail2  = (result.vec_out2 == 16'sh7fff) || (result.vec_out2 == -16'sh8000);
  assign rail3  = (result.vec_out3 == 16'sh7fff) || (result.vec_out3 == -16'sh8000);

  // Every accepted item is followed by a result strobe
  `MVT_ASSERT_IMPLY(a_item_to_result, clk, rst, accept, ##3 result_strobe)

  // No result without an earlier accepted item
  `MVT_ASSERT_IMPLY(a_result_has_item, clk, rst, result_strobe, $past(accept, 3))

  // A clipped result shows at least one component at a rail
  `MVT_ASSERT_IMPLY(a_flag_at_rail, clk, rst, result_strobe && result.saturated_flag,
    (rail0 || rail1 || rail2 || rail3))

  // Out of reset the block is never busy
  `MVT_ASSERT_NEXT(a_ready_after_reset, clk, rst, 1'b1, !busy)

endmodule

bind matrix4_vector_transform_top mvt_checker u_checker (.*);
